// ===== rtl/core/ctsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsa_pkg
// Shared codes, tables and stage types for the calendar time step adjuster.
// ----------------------------------------------------------------------------
package ctsa_pkg;

    typedef enum logic [1:0] {
        CMD_ADD_MINUTE = 2'd0,
        CMD_SUB_MINUTE = 2'd1,
        CMD_ADD_DAY    = 2'd2,
        CMD_SUB_DAY    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DAY_NONE = 2'd0,
        DAY_FWD  = 2'd1,
        DAY_BACK = 2'd2
    } day_op_t;

    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [3:0] MONTH_LAST = 4'd12;
    localparam logic [3:0] MONTH_FEB  = 4'd2;
    localparam logic [3:0] MONTH_MAR  = 4'd3;
    localparam logic [4:0] DATE_LONG  = 5'd31;
    localparam logic [4:0] DATE_FEB   = 5'd28;
    localparam logic [4:0] DATE_LEAP  = 5'd29;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    typedef logic [4:0] month_len_t [12];
    localparam month_len_t MONTH_LEN = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                         5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    // Non-leap length; month codes outside 1..12 count as 31 days.
    function automatic logic [4:0] len_of(input logic [3:0] month);
        logic [4:0] len;
        if (month >= 4'd1 && month <= MONTH_LAST)
            len = MONTH_LEN[month - 4'd1];
        else
            len = DATE_LONG;
        return len;
    endfunction

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
    } ymd_t;

    typedef struct packed {
        day_op_t    op;
        logic       clr;
        ymd_t       cur;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       leap;
        logic [4:0] len_cur;
        logic [4:0] len_prev;
    } stage_a_t;

    typedef struct packed {
        day_op_t    op;
        logic       clr;
        ymd_t       cur;
        ymd_t       fwd;
        ymd_t       bwd;
        logic [4:0] hour;
        logic [5:0] minute;
    } stage_b_t;

    typedef struct packed {
        ymd_t       ymd;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       clr;
    } result_t;

endpackage

// ===== rtl/core/ctsa_in_if.sv =====
// ----------------------------------------------------------------------------
// ctsa_in_if
// Request channel: command plus current calendar time.
// ----------------------------------------------------------------------------
interface ctsa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [6:0] cur_year;
    logic [3:0] cur_month;
    logic [4:0] cur_date;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;

    modport source (output valid, command, cur_year, cur_month, cur_date, cur_hour,
                    cur_minute, input ready);
    modport sink   (input valid, command, cur_year, cur_month, cur_date, cur_hour,
                    cur_minute, output ready);
endinterface

// ===== rtl/core/ctsa_out_if.sv =====
// ----------------------------------------------------------------------------
// ctsa_out_if
// Result channel: adjusted calendar time and seconds clear flag.
// ----------------------------------------------------------------------------
interface ctsa_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] new_year;
    logic [3:0] new_month;
    logic [4:0] new_date;
    logic [4:0] new_hour;
    logic [5:0] new_minute;
    logic       clear_seconds;

    modport source (output valid, new_year, new_month, new_date, new_hour, new_minute,
                    clear_seconds, input ready);
    modport sink   (input valid, new_year, new_month, new_date, new_hour, new_minute,
                    clear_seconds, output ready);
endinterface

// ===== rtl/core/calendar_time_step_adjust_unit.sv =====
// ----------------------------------------------------------------------------
// calendar_time_step_adjust_unit
// Steps a calendar time by one minute or one day, forwards or backwards.
// ----------------------------------------------------------------------------
// Usage:
//   request carries a command (add/remove minute, add/remove day) and the
//   current year, month, date, hour and minute. result carries the adjusted
//   time and clear_seconds, set for minute commands.
//   One result beat per request beat, in order.
// Throughput: one beat per cycle while result.ready stays high. Three register stages:
//   A - minute/hour step, day carry decision, leap flag, month lengths
//   B - forward and backward day candidates computed side by side
//   C - selection by day operation into the output register
// Each stage holds a valid bit and moves when the stage after it is empty or
// moving, so bubbles close up and a stalled receiver holds the output beat
// steady; the stall backs up stage by stage until request.ready drops.
// Reset: rst_n clears all valid bits at once; no items survive reset. There
// is no stored calendar state.
// ----------------------------------------------------------------------------
module calendar_time_step_adjust_unit (
    input  logic               clk,
    input  logic               rst_n,
    ctsa_in_if.sink            request,
    ctsa_out_if.source         result
);

    // Stage control: valid bits and advance enables.
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic a_adv;
    logic b_adv;
    logic c_adv;

    ctsa_pkg::stage_a_t a_reg;
    ctsa_pkg::stage_a_t a_next;
    ctsa_pkg::stage_b_t b_reg;
    ctsa_pkg::stage_b_t b_next;
    ctsa_pkg::result_t  c_reg;
    ctsa_pkg::result_t  c_next;

    assign c_adv = !c_valid_reg || result.ready;
    assign b_adv = !b_valid_reg || c_adv;
    assign a_adv = !a_valid_reg || b_adv;
    assign request.ready = a_adv;

    // ---------------- Stage A: time of day step ----------------
    always_comb
    begin
        a_next.op       = ctsa_pkg::DAY_NONE;
        a_next.clr      = 1'b0;
        a_next.cur      = '{year: request.cur_year, month: request.cur_month,
                            date: request.cur_date};
        a_next.hour     = request.cur_hour;
        a_next.minute   = request.cur_minute;
        a_next.leap     = (request.cur_year[1:0] == 2'd0);
        a_next.len_cur  = ctsa_pkg::len_of(request.cur_month);
        a_next.len_prev = ctsa_pkg::len_of(request.cur_month - 4'd1);
        case (ctsa_pkg::cmd_t'(request.command))
            ctsa_pkg::CMD_ADD_MINUTE:
            begin
                a_next.clr = 1'b1;
                if (request.cur_minute >= ctsa_pkg::MINUTE_MAX)
                begin
                    a_next.minute = 6'd0;
                    if (request.cur_hour >= ctsa_pkg::HOUR_MAX)
                    begin
                        a_next.hour = 5'd0;
                        a_next.op   = ctsa_pkg::DAY_FWD;
                    end
                    else
                    begin
                        a_next.hour = request.cur_hour + 5'd1;
                    end
                end
                else
                begin
                    a_next.minute = request.cur_minute + 6'd1;
                end
            end
            ctsa_pkg::CMD_SUB_MINUTE:
            begin
                a_next.clr = 1'b1;
                if (request.cur_minute == 6'd0)
                begin
                    a_next.minute = ctsa_pkg::MINUTE_MAX;
                    if (request.cur_hour == 5'd0)
                    begin
                        a_next.hour = ctsa_pkg::HOUR_MAX;
                        a_next.op   = ctsa_pkg::DAY_BACK;
                    end
                    else if (request.cur_hour > ctsa_pkg::HOUR_MAX + 5'd1)
                    begin
                        a_next.hour = ctsa_pkg::HOUR_MAX;
                    end
                    else
                    begin
                        a_next.hour = request.cur_hour - 5'd1;
                    end
                end
                else if (request.cur_minute > ctsa_pkg::MINUTE_MAX + 6'd1)
                begin
                    a_next.minute = ctsa_pkg::MINUTE_MAX;
                end
                else
                begin
                    a_next.minute = request.cur_minute - 6'd1;
                end
            end
            ctsa_pkg::CMD_ADD_DAY:
            begin
                a_next.op = ctsa_pkg::DAY_FWD;
            end
            default:
            begin
                a_next.op = ctsa_pkg::DAY_BACK;
            end
        endcase
    end

    // ---------------- Stage B: day candidates ----------------
    always_comb
    begin
        b_next.op     = a_reg.op;
        b_next.clr    = a_reg.clr;
        b_next.cur    = a_reg.cur;
        b_next.hour   = a_reg.hour;
        b_next.minute = a_reg.minute;

        // Forward step
        b_next.fwd = a_reg.cur;
        if (a_reg.cur.month == ctsa_pkg::MONTH_FEB && a_reg.cur.date == ctsa_pkg::DATE_FEB
            && a_reg.leap)
        begin
            b_next.fwd.date = ctsa_pkg::DATE_LEAP;
        end
        else if (a_reg.cur.date >= a_reg.len_cur)
        begin
            b_next.fwd.date = 5'd1;
            if (a_reg.cur.month >= ctsa_pkg::MONTH_LAST)
            begin
                b_next.fwd.month = 4'd1;
                b_next.fwd.year  = (a_reg.cur.year >= ctsa_pkg::YEAR_MAX) ? 7'd0
                                                                           : a_reg.cur.year + 7'd1;
            end
            else
            begin
                b_next.fwd.month = a_reg.cur.month + 4'd1;
            end
        end
        else
        begin
            b_next.fwd.date = a_reg.cur.date + 5'd1;
        end

        // Backward step
        b_next.bwd = a_reg.cur;
        if (a_reg.cur.month == ctsa_pkg::MONTH_MAR && a_reg.cur.date == 5'd1 && a_reg.leap)
        begin
            b_next.bwd.month = ctsa_pkg::MONTH_FEB;
            b_next.bwd.date  = ctsa_pkg::DATE_LEAP;
        end
        else if (a_reg.cur.date == 5'd1)
        begin
            if (a_reg.cur.month <= 4'd1)
            begin
                b_next.bwd.year  = (a_reg.cur.year == 7'd0) ? ctsa_pkg::YEAR_MAX
                                                            : a_reg.cur.year - 7'd1;
                b_next.bwd.month = ctsa_pkg::MONTH_LAST;
                b_next.bwd.date  = ctsa_pkg::DATE_LONG;
            end
            else if (a_reg.cur.month > ctsa_pkg::MONTH_LAST)
            begin
                b_next.bwd.month = ctsa_pkg::MONTH_LAST;
                b_next.bwd.date  = ctsa_pkg::DATE_LONG;
            end
            else
            begin
                b_next.bwd.month = a_reg.cur.month - 4'd1;
                b_next.bwd.date  = a_reg.len_prev;
            end
        end
        else
        begin
            // date zero wraps to 31 in the same month
            b_next.bwd.date = a_reg.cur.date - 5'd1;
        end
    end

    // ---------------- Stage C: selection ----------------
    always_comb
    begin
        c_next.hour   = b_reg.hour;
        c_next.minute = b_reg.minute;
        c_next.clr    = b_reg.clr;
        case (b_reg.op)
            ctsa_pkg::DAY_FWD:  c_next.ymd = b_reg.fwd;
            ctsa_pkg::DAY_BACK: c_next.ymd = b_reg.bwd;
            default:            c_next.ymd = b_reg.cur;
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_valid_reg <= request.valid;
            if (b_adv)
                b_valid_reg <= a_valid_reg;
            if (c_adv)
                c_valid_reg <= b_valid_reg;
        end
    end

    // Payload, loaded only with a live beat
    always_ff @(posedge clk)
    begin
        if (a_adv && request.valid)
            a_reg <= a_next;
        if (b_adv && a_valid_reg)
            b_reg <= b_next;
        if (c_adv && b_valid_reg)
            c_reg <= c_next;
    end

    assign result.valid         = c_valid_reg;
    assign result.new_year      = c_reg.ymd.year;
    assign result.new_month     = c_reg.ymd.month;
    assign result.new_date      = c_reg.ymd.date;
    assign result.new_hour      = c_reg.hour;
    assign result.new_minute    = c_reg.minute;
    assign result.clear_seconds = c_reg.clr;

endmodule

// ===== rtl/core/ctsa_checker.sv =====
// ----------------------------------------------------------------------------
// ctsa_checker
// Port-level checks for the calendar time step adjuster, bound to the top.
// ----------------------------------------------------------------------------
module ctsa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] new_year,
    input logic [3:0] new_month,
    input logic [4:0] new_date,
    input logic [4:0] new_hour,
    input logic [5:0] new_minute,
    input logic       clear_seconds
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_year) && $stable(new_month)
        && $stable(new_date) && $stable(new_hour) && $stable(new_minute)
        && $stable(clear_seconds))
        else $error("result beat changed under stall");

    // minute steps always land on a legal minute
    a_minute: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clear_seconds |-> new_minute <= 6'd59)
        else $error("minute step out of range");

    // open receiver never backs up the request side
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("request stalled with receiver ready");

    // with no stall, an accepted request beat passes through stages A, B and C to result valid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result beat late");

    // nothing leaves during reset
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid in reset");

endmodule

bind calendar_time_step_adjust_unit ctsa_checker u_ctsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (request.valid),
    .in_ready      (request.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .new_year      (result.new_year),
    .new_month     (result.new_month),
    .new_date      (result.new_date),
    .new_hour      (result.new_hour),
    .new_minute    (result.new_minute),
    .clear_seconds (result.clear_seconds)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for calendar_time_step_adjust_unit. Every request beat
// is run through a local calendar predictor and the expected time is queued;
// every result beat is checked field by field against the oldest entry.
// Directed calendar corners and out-of-range fields come first, then a long
// random mix with idle stretches, random gaps and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    // local names for the shared codes and limits
    typedef ctsa_pkg::cmd_t cmd_t;
    localparam cmd_t       CMD_ADD_MINUTE = ctsa_pkg::CMD_ADD_MINUTE;
    localparam cmd_t       CMD_SUB_MINUTE = ctsa_pkg::CMD_SUB_MINUTE;
    localparam cmd_t       CMD_ADD_DAY    = ctsa_pkg::CMD_ADD_DAY;
    localparam cmd_t       CMD_SUB_DAY    = ctsa_pkg::CMD_SUB_DAY;
    localparam logic [6:0] YEAR_MAX       = ctsa_pkg::YEAR_MAX;
    localparam logic [3:0] MONTH_LAST     = ctsa_pkg::MONTH_LAST;
    localparam logic [3:0] MONTH_FEB      = ctsa_pkg::MONTH_FEB;
    localparam logic [3:0] MONTH_MAR      = ctsa_pkg::MONTH_MAR;
    localparam logic [4:0] DATE_LONG      = ctsa_pkg::DATE_LONG;
    localparam logic [4:0] DATE_FEB       = ctsa_pkg::DATE_FEB;
    localparam logic [4:0] DATE_LEAP      = ctsa_pkg::DATE_LEAP;
    localparam logic [4:0] HOUR_MAX       = ctsa_pkg::HOUR_MAX;
    localparam logic [5:0] MINUTE_MAX     = ctsa_pkg::MINUTE_MAX;

    localparam time        CLK_PERIOD       = 12ns;
    localparam int         WATCHDOG_LIMIT   = 2000;
    localparam int         HOLDOFF_CYCLES   = 200;
    localparam int         DRAIN_CYCLES     = 10;
    localparam int         MAX_REPORTS      = 10;
    localparam int         RANDOM_ITEMS     = 480;
    // thresholds the block uses for out-of-range hours and minutes on removal
    localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
    localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;

    // one request beat as the predictor sees it
    typedef struct packed {
        cmd_t       command;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [4:0] hour;
        logic [5:0] minute;
    } adjust_req_t;

    // one result beat
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       clear_seconds;
    } adjusted_time_t;

    logic clk;
    logic rst_n;

    ctsa_in_if  req_if ();
    ctsa_out_if res_if ();

    calendar_time_step_adjust_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    // expected adjusted times, oldest first
    adjusted_time_t expected_times[$];

    int  mismatches;
    int  results_checked;
    int  orphan_results;
    int  requests_by_cmd[4];
    int  request_stall_cycles;
    int  watchdog_count;

    // idling controls, flipped by the test tasks and the result receiver
    bit  in_idle_on;
    bit  out_idle_on;
    bit  holdoff_request;
    bit  holdoff_active;

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------

    // non-leap month length; codes 0 and 13..15 count as 31 days
    function automatic logic [4:0] days_in(input logic [3:0] month);
        case (month)
            4'd2:                    return DATE_FEB;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                 return DATE_LONG;
        endcase
    endfunction

    function automatic void roll_day_forward(inout logic [6:0] y, inout logic [3:0] m,
                                             inout logic [4:0] d);
        logic leap;
        leap = (y[1:0] == 2'd0);
        if (m == MONTH_FEB && d == DATE_FEB && leap)
            d = DATE_LEAP;
        else if (d >= days_in(m))
        begin
            d = 5'd1;
            if (m >= MONTH_LAST)
            begin
                m = 4'd1;
                y = (y >= YEAR_MAX) ? 7'd0 : y + 7'd1;
            end
            else
                m = m + 4'd1;
        end
        else
            d = d + 5'd1;
    endfunction

    function automatic void roll_day_backward(inout logic [6:0] y, inout logic [3:0] m,
                                              inout logic [4:0] d);
        logic leap;
        leap = (y[1:0] == 2'd0);
        if (m == MONTH_MAR && d == 5'd1 && leap)
        begin
            m = MONTH_FEB;
            d = DATE_LEAP;
        end
        else if (d == 5'd1)
        begin
            if (m <= 4'd1)
            begin
                // month 0 behaves as January
                y = (y == 7'd0) ? YEAR_MAX : y - 7'd1;
                m = MONTH_LAST;
                d = DATE_LONG;
            end
            else if (m > MONTH_LAST)
            begin
                m = MONTH_LAST;
                d = DATE_LONG;
            end
            else
            begin
                m = m - 4'd1;
                d = days_in(m);
            end
        end
        else
            d = d - 5'd1;   // date 0 wraps to 31 in the same month
    endfunction

    function automatic adjusted_time_t step_calendar(input adjust_req_t r);
        adjusted_time_t t;
        logic [6:0] y;
        logic [3:0] m;
        logic [4:0] d;
        logic [4:0] h;
        logic [5:0] mi;
        logic       clr;
        y   = r.year;
        m   = r.month;
        d   = r.date;
        h   = r.hour;
        mi  = r.minute;
        clr = 1'b0;
        case (r.command)
            CMD_ADD_MINUTE:
            begin
                clr = 1'b1;
                if (mi >= MINUTE_MAX)
                begin
                    mi = 6'd0;
                    if (h >= HOUR_MAX)
                    begin
                        h = 5'd0;
                        roll_day_forward(y, m, d);
                    end
                    else
                        h = h + 5'd1;
                end
                else
                    mi = mi + 6'd1;
            end
            CMD_SUB_MINUTE:
            begin
                clr = 1'b1;
                if (mi == 6'd0)
                begin
                    mi = MINUTE_MAX;
                    if (h == 5'd0)
                    begin
                        h = HOUR_MAX;
                        roll_day_backward(y, m, d);
                    end
                    else if (h > HOURS_PER_DAY)
                        h = HOUR_MAX;
                    else
                        h = h - 5'd1;
                end
                else if (mi > MINUTES_PER_HOUR)
                    mi = MINUTE_MAX;
                else
                    mi = mi - 6'd1;
            end
            CMD_ADD_DAY:
                roll_day_forward(y, m, d);
            default:
                roll_day_backward(y, m, d);
        endcase
        t.year          = y;
        t.month         = m;
        t.date          = d;
        t.hour          = h;
        t.minute        = mi;
        t.clear_seconds = clr;
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic adjust_req_t make_req(input cmd_t c, input int y, input int m,
                                             input int d, input int h, input int mi);
        adjust_req_t r;
        r.command = c;
        r.year    = 7'(y);
        r.month   = 4'(m);
        r.date    = 5'(d);
        r.hour    = 5'(h);
        r.minute  = 6'(mi);
        return r;
    endfunction

    // mostly short, now and then long
    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // valid calendar time with a bias towards the rollover points,
    // or raw bit patterns when well_formed is clear
    function automatic adjust_req_t random_request(input bit well_formed);
        adjust_req_t r;
        int          month_len;
        r.command = cmd_t'($urandom_range(0, 3));
        if (!well_formed)
        begin
            r.year   = 7'($urandom);
            r.month  = 4'($urandom);
            r.date   = 5'($urandom);
            r.hour   = 5'($urandom);
            r.minute = 6'($urandom);
            return r;
        end
        case ($urandom_range(0, 3))
            0:       r.year = 7'd0;
            1:       r.year = YEAR_MAX;
            default: r.year = 7'($urandom_range(0, 99));
        endcase
        case ($urandom_range(0, 5))
            0:       r.month = MONTH_FEB;
            1:       r.month = MONTH_MAR;
            2:       r.month = MONTH_LAST;
            default: r.month = 4'($urandom_range(1, 12));
        endcase
        month_len = days_in(r.month);
        if (r.month == MONTH_FEB && r.year[1:0] == 2'd0)
            month_len = DATE_LEAP;
        case ($urandom_range(0, 4))
            0:       r.date = 5'd1;
            1:       r.date = 5'(month_len);
            2:       r.date = 5'(month_len - 1);
            default: r.date = 5'($urandom_range(1, month_len));
        endcase
        case ($urandom_range(0, 2))
            0:       r.hour = 5'd0;
            1:       r.hour = HOUR_MAX;
            default: r.hour = 5'($urandom_range(0, 23));
        endcase
        case ($urandom_range(0, 2))
            0:       r.minute = 6'd0;
            1:       r.minute = MINUTE_MAX;
            default: r.minute = 6'($urandom_range(0, 59));
        endcase
        return r;
    endfunction

    // drives one request beat, waits for it to go in, then maybe idles
    task automatic send_item(input adjust_req_t r);
        int gap;
        @(negedge clk);
        req_if.valid      = 1'b1;
        req_if.command    = r.command;
        req_if.cur_year   = r.year;
        req_if.cur_month  = r.month;
        req_if.cur_date   = r.date;
        req_if.cur_hour   = r.hour;
        req_if.cur_minute = r.minute;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        if (in_idle_on && $urandom_range(0, 99) < 30)
        begin
            gap = pick_stall();
            @(negedge clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // month, year and leap-day boundaries reached from both directions
    task automatic test_calendar_edges();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        send_item(make_req(CMD_ADD_MINUTE, 99, 12, 31, 23, 59));  // century wrap forwards
        send_item(make_req(CMD_SUB_MINUTE,  0,  1,  1,  0,  0));  // century wrap backwards
        send_item(make_req(CMD_ADD_DAY,    24,  2, 28, 10, 30));  // leap day appears
        send_item(make_req(CMD_ADD_DAY,    23,  2, 28,  5,  5));  // no leap day
        send_item(make_req(CMD_ADD_DAY,    24,  2, 29,  0,  0));  // leap day to March
        send_item(make_req(CMD_SUB_DAY,    24,  3,  1, 12,  0));  // back onto leap day
        send_item(make_req(CMD_SUB_DAY,    23,  3,  1, 12,  0));  // back onto 28 Feb
        send_item(make_req(CMD_SUB_DAY,    50,  5,  1,  1,  1));  // into a 30-day month
        send_item(make_req(CMD_ADD_DAY,    50,  4, 30, 22, 58));
        send_item(make_req(CMD_ADD_MINUTE, 10,  6, 15, 10, 59));  // hour carry only
        send_item(make_req(CMD_SUB_MINUTE, 10,  6, 15, 10,  0));  // hour borrow only
        send_item(make_req(CMD_SUB_MINUTE,  0,  3,  1,  0,  0));  // borrow into leap day
        send_item(make_req(CMD_ADD_DAY,    99, 12, 31,  0,  0));
        send_item(make_req(CMD_SUB_DAY,     0,  1,  1, 23, 59));
    endtask

    // fields beyond their calendar range, up to the all-ones patterns
    task automatic test_field_limits();
        send_item(make_req(CMD_ADD_DAY,     7,  0, 31,  3,  3));  // month 0 is 31 days long
        send_item(make_req(CMD_ADD_DAY,     7, 13, 31,  3,  3));  // past December
        send_item(make_req(CMD_SUB_DAY,     7, 15,  1,  3,  3));  // month above 12, 1st
        send_item(make_req(CMD_SUB_DAY,     7,  0,  1,  3,  3));  // month 0 acts as January
        send_item(make_req(CMD_ADD_DAY,     8,  4,  0,  0,  0));  // date zero forwards
        send_item(make_req(CMD_SUB_DAY,     8,  4,  0,  0,  0));  // date zero wraps to 31
        send_item(make_req(CMD_ADD_MINUTE, 127, 15, 31, 31, 63)); // every bit set
        send_item(make_req(CMD_SUB_MINUTE, 20,  7, 10, 25,  0));  // hour above 24
        send_item(make_req(CMD_SUB_MINUTE, 20,  7, 10, 24,  0));
        send_item(make_req(CMD_SUB_MINUTE, 20,  7, 10,  6, 61)); // minute above 60
        send_item(make_req(CMD_SUB_MINUTE, 20,  7, 10,  6, 60));
        send_item(make_req(CMD_SUB_DAY,    127,  1,  1,  9,  9)); // year above range backwards
        send_item(make_req(CMD_ADD_DAY,    100, 12, 31,  9,  9)); // year above range forwards
    endtask

    // back-to-back first, then with gaps on both sides or on the sender side only
    task automatic test_random_mix();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 5)
            begin
                in_idle_on  = 1'b1;
                out_idle_on = 1'b1;
            end
            else if (i == (RANDOM_ITEMS * 3) / 5)
                out_idle_on = 1'b0;   // sender gaps only for a stretch
            else if (i == (RANDOM_ITEMS * 4) / 5)
                out_idle_on = 1'b1;
            send_item(random_request($urandom_range(0, 99) < 85));
        end
    endtask

    // receiver stops for a long stretch while the sender keeps offering
    task automatic test_receiver_holdoff();
        in_idle_on      = 1'b0;
        holdoff_request = 1'b1;
        wait (holdoff_active);
        for (int i = 0; i < 24; i++)
            send_item(random_request(1'b1));
        in_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin : main_sequence
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.command    = CMD_ADD_MINUTE;
        req_if.cur_year   = '0;
        req_if.cur_month  = '0;
        req_if.cur_date   = '0;
        req_if.cur_hour   = '0;
        req_if.cur_minute = '0;
        in_idle_on        = 1'b0;
        out_idle_on       = 1'b0;
        holdoff_request   = 1'b0;
        holdoff_active    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_calendar_edges();
        test_field_limits();
        test_random_mix();
        test_receiver_holdoff();
        test_random_mix();

        @(negedge clk);
        req_if.valid = 1'b0;
        // the watchdog bounds this wait
        while (expected_times.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests (add/remove minute %0d/%0d, add/remove day %0d/%0d),",
                 requests_by_cmd[0] + requests_by_cmd[1] + requests_by_cmd[2]
                 + requests_by_cmd[3], requests_by_cmd[CMD_ADD_MINUTE],
                 requests_by_cmd[CMD_SUB_MINUTE], requests_by_cmd[CMD_ADD_DAY],
                 requests_by_cmd[CMD_SUB_DAY]);
        $display("%0d results checked, %0d cycles with request held back, %0d mismatches.",
                 results_checked, request_stall_cycles, mismatches);
        if (mismatches == 0 && orphan_results == 0 && expected_times.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls plus the long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : result_receiver
        int gap;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                holdoff_active  = 1'b1;
                res_if.ready    = 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
                holdoff_active  = 1'b0;
            end
            else if (out_idle_on && $urandom_range(0, 99) < 30)
            begin
                gap          = pick_stall();
                res_if.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                res_if.ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: predict on request beats, check on result beats
    // ------------------------------------------------------------------------
    function automatic bit field_differs(input string name, input int unsigned want,
                                         input int unsigned got, input bit report);
        if (want == got)
            return 1'b0;
        if (report)
            $display("  %s: expected %0d, got %0d", name, want, got);
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        adjust_req_t    req;
        adjusted_time_t want;
        bit             report;
        bit             bad;
        if (rst_n)
        begin
            if (req_if.valid && !req_if.ready)
                request_stall_cycles++;
            if (req_if.valid && req_if.ready)
            begin
                req.command = cmd_t'(req_if.command);
                req.year    = req_if.cur_year;
                req.month   = req_if.cur_month;
                req.date    = req_if.cur_date;
                req.hour    = req_if.cur_hour;
                req.minute  = req_if.cur_minute;
                expected_times.push_back(step_calendar(req));
                requests_by_cmd[req.command]++;
            end
            if (res_if.valid && res_if.ready)
            begin
                if (expected_times.size() == 0)
                begin
                    orphan_results++;
                    if (orphan_results <= MAX_REPORTS)
                        $display("%t: result beat with nothing expected", $realtime);
                end
                else
                begin
                    want   = expected_times.pop_front();
                    report = (mismatches < MAX_REPORTS);
                    if (report && (res_if.new_year !== want.year
                        || res_if.new_month !== want.month || res_if.new_date !== want.date
                        || res_if.new_hour !== want.hour || res_if.new_minute !== want.minute
                        || res_if.clear_seconds !== want.clear_seconds))
                        $display("%t: mismatch on result %0d", $realtime, results_checked);
                    bad = 1'b0;
                    bad |= field_differs("new_year", want.year, res_if.new_year, report);
                    bad |= field_differs("new_month", want.month, res_if.new_month, report);
                    bad |= field_differs("new_date", want.date, res_if.new_date, report);
                    bad |= field_differs("new_hour", want.hour, res_if.new_hour, report);
                    bad |= field_differs("new_minute", want.minute, res_if.new_minute, report);
                    bad |= field_differs("clear_seconds", want.clear_seconds,
                                         res_if.clear_seconds, report);
                    // X or Z on an output counts as wrong even if the integer compare hides it
                    if ($isunknown({res_if.new_year, res_if.new_month, res_if.new_date,
                                    res_if.new_hour, res_if.new_minute, res_if.clear_seconds}))
                        bad = 1'b1;
                    if (bad)
                        mismatches++;
                    results_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any beat on either side ends the run
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            watchdog_count = 0;
        else
        begin
            watchdog_count++;
            if (watchdog_count >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: %0d cycles without a beat, %0d results outstanding",
                         watchdog_count, expected_times.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
rtl/core/ctsa_pkg.sv
rtl/core/ctsa_in_if.sv
rtl/core/ctsa_out_if.sv
rtl/core/calendar_time_step_adjust_unit.sv
rtl/core/ctsa_checker.sv
dv/testbench.sv
